[design/sat_pkg.sv]
// Shared types, constants and a helper function of the set-associative tag lookup.
`default_nettype none

package sat_pkg;

    localparam int ADDR_W      = 64;
    localparam int DELAY_W     = 8;
    localparam int FILL_WAY_W  = 3;
    localparam int LFSR_W      = 8;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 8;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 16;

    localparam int DEF_NUM_SETS         = 64;
    localparam int DEF_NUM_WAYS         = 8;
    localparam int DEF_LINE_OFFSET_BITS = 6;

    localparam logic [CFG_INDEX_W-1:0] CFG_HIT_DELAY  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MISS_DELAY = 8'd1;

    localparam logic [DELAY_W-1:0] HIT_DELAY_RESET  = 8'd1;
    localparam logic [DELAY_W-1:0] MISS_DELAY_RESET = 8'd20;

    // Feedback taps at bits 7, 3, 2 and 1.
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 8'h80 | 8'h08 | 8'h04 | 8'h02;
    localparam logic [LFSR_W-1:0] LFSR_LOW_MASK = 8'h7F;

    typedef struct packed {
        logic                  hit;
        logic                  full;
        logic [FILL_WAY_W-1:0] way;
    } lookup_t;

    typedef struct packed {
        logic [FILL_WAY_W-1:0] fill_way;
        logic                  filled;
        logic [DELAY_W-1:0]    delay;
        logic                  hit;
    } result_t;

    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
        logic fb;
        fb = ^(s & LFSR_TAPS);
        return {s[LFSR_W-2:0] & LFSR_LOW_MASK[LFSR_W-2:0], ~fb};
    endfunction

endpackage

`default_nettype wire

[design/sat_tag_ram.sv]
// Synchronous tag and valid memory with one write port and one registered read port.
`default_nettype none

module sat_tag_ram #(
    parameter int DEPTH  = sat_pkg::DEF_NUM_SETS,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[design/sat_line_split.sv]
// Splits a line number into set index and tag, by slicing or by long division eight bits per cycle.
`default_nettype none

module sat_line_split #(
    parameter int NUM_SETS = sat_pkg::DEF_NUM_SETS,
    parameter int LINE_W   = sat_pkg::ADDR_W - sat_pkg::DEF_LINE_OFFSET_BITS,
    parameter int IDX_W    = $clog2(NUM_SETS),
    parameter int TAG_W    = LINE_W - IDX_W
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [LINE_W-1:0] line_in,
    output logic                   done,
    output logic      [IDX_W-1:0]  set_idx,
    output logic      [TAG_W-1:0]  tag
);

    localparam bit SETS_POW2 = ((1 << IDX_W) == NUM_SETS);

    generate
        if (SETS_POW2)
        begin : g_slice
            logic unused_clk_rst;
            assign unused_clk_rst = clk ^ rst_n;
            assign done    = start;
            assign set_idx = line_in[IDX_W-1:0];
            assign tag     = line_in[LINE_W-1 -: TAG_W];
        end
        else
        begin : g_divide
            localparam int DIG_W   = 8;
            localparam int NUM_DIG = (LINE_W + DIG_W - 1) / DIG_W;
            localparam int PAD_W   = NUM_DIG * DIG_W;
            localparam int CNT_W   = $clog2(NUM_DIG + 1);
            localparam int PART_W  = IDX_W + DIG_W;
            localparam int SHIFT   = PART_W + IDX_W;
            localparam int RECIP_W = PART_W + 1;
            localparam int PROD_W  = PART_W + RECIP_W;
            localparam logic [IDX_W-1:0] DIVISOR = IDX_W'(NUM_SETS);
            localparam logic [RECIP_W-1:0] RECIP =
                RECIP_W'(((64'd1 << SHIFT) + 64'(NUM_SETS) - 64'd1) / 64'(NUM_SETS));
            localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_DIG - 1);

            logic              busy_reg, busy_next;
            logic              done_reg, done_next;
            logic [CNT_W-1:0]  cnt_reg, cnt_next;
            logic [PAD_W-1:0]  quo_reg, quo_next;
            logic [IDX_W-1:0]  rem_reg, rem_next;
            logic [PART_W-1:0] part;
            logic [PROD_W-1:0] prod;
            logic [DIG_W-1:0]  digit;
            logic [PART_W-1:0] back;

            // Each step divides the running remainder and the next digit through a reciprocal.
            always_comb
            begin
                busy_next = busy_reg;
                done_next = 1'b0;
                cnt_next  = cnt_reg;
                quo_next  = quo_reg;
                rem_next  = rem_reg;
                part      = {rem_reg, quo_reg[PAD_W-1 -: DIG_W]};
                prod      = PROD_W'(part) * PROD_W'(RECIP);
                digit     = prod[SHIFT +: DIG_W];
                back      = PART_W'(digit) * PART_W'(DIVISOR);
                if (start)
                begin
                    busy_next = 1'b1;
                    cnt_next  = '0;
                    quo_next  = PAD_W'(line_in);
                    rem_next  = '0;
                end
                else if (busy_reg)
                begin
                    quo_next = {quo_reg[PAD_W-DIG_W-1:0], digit};
                    rem_next = IDX_W'(part - back);
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == LAST_STEP)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                    cnt_reg  <= '0;
                end
                else
                begin
                    busy_reg <= busy_next;
                    done_reg <= done_next;
                    cnt_reg  <= cnt_next;
                end
            end

            always_ff @(posedge clk)
            begin
                quo_reg <= quo_next;
                rem_reg <= rem_next;
            end

            assign done    = done_reg;
            assign set_idx = rem_reg;
            assign tag     = quo_reg[TAG_W-1:0];
        end
    endgenerate

endmodule

`default_nettype wire

[design/sat_way_select.sv]
// Compares the ways of one set and flags a hit, else picks the first free way or the random victim.
`default_nettype none

module sat_way_select #(
    parameter int NUM_WAYS = sat_pkg::DEF_NUM_WAYS,
    parameter int TAG_W    = 52
) (
    input  wire logic [NUM_WAYS-1:0]       valid,
    input  wire logic [NUM_WAYS*TAG_W-1:0] tags,
    input  wire logic [TAG_W-1:0]          tag,
    input  wire logic [sat_pkg::LFSR_W-1:0] lfsr_next,
    output sat_pkg::lookup_t               lookup
);

    localparam int RECIP_W = 17;
    localparam int PROD_W  = RECIP_W + sat_pkg::LFSR_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((65536 + NUM_WAYS - 1) / NUM_WAYS);
    localparam logic [sat_pkg::LFSR_W-1:0] WAYS = sat_pkg::LFSR_W'(NUM_WAYS);

    logic                                hit;
    logic                                free_found;
    logic [sat_pkg::FILL_WAY_W-1:0]      free_way;
    logic [PROD_W-1:0]                   prod;
    logic [sat_pkg::LFSR_W-1:0]          quo;
    logic [sat_pkg::LFSR_W-1:0]          rem;

    always_comb
    begin
        hit        = 1'b0;
        free_found = 1'b0;
        free_way   = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (valid[w] && (tags[w*TAG_W +: TAG_W] == tag))
            begin
                hit = 1'b1;
            end
        end
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (!valid[w])
            begin
                free_found = 1'b1;
                free_way   = sat_pkg::FILL_WAY_W'(w);
            end
        end
    end

    // The victim is the LFSR value modulo the way count, through a reciprocal.
    assign prod = PROD_W'(lfsr_next) * PROD_W'(RECIP);
    assign quo  = prod[16 +: sat_pkg::LFSR_W];
    assign rem  = lfsr_next - sat_pkg::LFSR_W'(quo * WAYS);

    assign lookup.hit  = hit;
    assign lookup.full = !free_found;
    assign lookup.way  = hit ? '0 :
                         (free_found ? free_way : rem[sat_pkg::FILL_WAY_W-1:0]);

endmodule

`default_nettype wire

[design/set_assoc_tag_lookup_lfsr_replace.sv]
// Top level of the set-associative tag lookup with LFSR replacement.
//
// A fetch beat on the slave stream carries the byte address in tdata and the
// cacheable flag in tuser. Each fetch returns one result beat on the master
// stream: hit, delay, filled and fill way. Fetches are handled one at a time.
// With a power-of-two set count a cacheable fetch passes from accept to
// result through the tag memory read, then compare and write back, then the
// load of the output register; a non-cacheable fetch skips the first two.
// With another set count a divider splits the line number first, eight bits
// per cycle. The next fetch is taken once the previous result has moved to
// the output register.
// After reset the block clears the valid bits of the memory, one set per
// cycle, and takes no fetch until done. The LFSR resets to zero and the
// delays to 1 and 20. Configuration writes are always taken.
// When the receiver stalls, the result waits in the output register; one
// more fetch may be taken and processed, and it then waits for that slot.
`default_nettype none

module set_assoc_tag_lookup_lfsr_replace #(
    parameter int NUM_SETS         = sat_pkg::DEF_NUM_SETS,
    parameter int NUM_WAYS         = sat_pkg::DEF_NUM_WAYS,
    parameter int LINE_OFFSET_BITS = sat_pkg::DEF_LINE_OFFSET_BITS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [sat_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // fetch_address[63:0]
    input  wire logic                             s_axis_tuser,   // cacheable
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic      [sat_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // hit, delay[7:0], filled,
                                                                  // fill_way[2:0], zero pad
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [sat_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [sat_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int  LINE_W    = sat_pkg::ADDR_W - LINE_OFFSET_BITS;
    localparam int  IDX_W     = $clog2(NUM_SETS);
    localparam bit  SETS_POW2 = ((1 << IDX_W) == NUM_SETS);
    localparam int  TAG_W     = LINE_W - IDX_W + (SETS_POW2 ? 0 : 1);
    localparam int  TAGS_W    = NUM_WAYS * TAG_W;
    localparam int  ROW_W     = NUM_WAYS + TAGS_W;
    localparam logic [IDX_W-1:0] LAST_SET = IDX_W'(NUM_SETS - 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_DIV   = 5'b00100,
        S_LOOK  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t                           state_reg, state_next;
    logic [IDX_W-1:0]                 clr_cnt_reg, clr_cnt_next;
    logic [sat_pkg::LFSR_W-1:0]       lfsr_reg, lfsr_next;
    logic                             out_valid_reg, out_valid_next;
    logic [sat_pkg::DELAY_W-1:0]      hit_delay_reg;
    logic [sat_pkg::DELAY_W-1:0]      miss_delay_reg;
    logic [IDX_W-1:0]                 set_reg, set_next;
    logic [TAG_W-1:0]                 tag_reg, tag_next;
    sat_pkg::result_t                 res_reg, res_next;
    sat_pkg::result_t                 out_data_reg, out_data_next;

    logic                             in_fire;
    logic                             split_start;
    logic                             split_done;
    logic [IDX_W-1:0]                 split_set;
    logic [TAG_W-1:0]                 split_tag;
    logic                             rd_en;
    logic [ROW_W-1:0]                 rd_row;
    logic                             wr_en;
    logic [IDX_W-1:0]                 wr_addr;
    logic [ROW_W-1:0]                 wr_data;
    logic [NUM_WAYS-1:0]              row_valid;
    logic [TAGS_W-1:0]                row_tags;
    logic [NUM_WAYS-1:0]              new_valid;
    logic [TAGS_W-1:0]                new_tags;
    logic [sat_pkg::LFSR_W-1:0]       lfsr_stepped;
    sat_pkg::lookup_t                 lookup;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign split_start   = in_fire && s_axis_tuser;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = sat_pkg::OUT_TDATA_W'(out_data_reg);

    sat_line_split #(
        .NUM_SETS (NUM_SETS),
        .LINE_W   (LINE_W),
        .IDX_W    (IDX_W),
        .TAG_W    (TAG_W)
    ) u_split (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (split_start),
        .line_in (s_axis_tdata[sat_pkg::ADDR_W-1:LINE_OFFSET_BITS]),
        .done    (split_done),
        .set_idx (split_set),
        .tag     (split_tag)
    );

    sat_tag_ram #(
        .DEPTH  (NUM_SETS),
        .WIDTH  (ROW_W),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (split_set),
        .rd_data (rd_row),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign row_valid    = rd_row[ROW_W-1 -: NUM_WAYS];
    assign row_tags     = rd_row[TAGS_W-1:0];
    assign lfsr_stepped = sat_pkg::lfsr_step(lfsr_reg);

    sat_way_select #(
        .NUM_WAYS (NUM_WAYS),
        .TAG_W    (TAG_W)
    ) u_select (
        .valid     (row_valid),
        .tags      (row_tags),
        .tag       (tag_reg),
        .lfsr_next (lfsr_stepped),
        .lookup    (lookup)
    );

    always_comb
    begin
        new_valid = row_valid;
        new_tags  = row_tags;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (sat_pkg::FILL_WAY_W'(w) == lookup.way)
            begin
                new_valid[w]                = 1'b1;
                new_tags[w*TAG_W +: TAG_W]  = tag_reg;
            end
        end
    end

    assign rd_en   = ((state_reg == S_IDLE) && split_start && split_done)
                     || ((state_reg == S_DIV) && split_done);
    assign wr_en   = (state_reg == S_CLEAR) || ((state_reg == S_LOOK) && !lookup.hit);
    assign wr_addr = (state_reg == S_CLEAR) ? clr_cnt_reg : set_reg;
    assign wr_data = (state_reg == S_CLEAR) ? '0 : {new_valid, new_tags};

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        lfsr_next      = lfsr_reg;
        set_next       = set_reg;
        tag_next       = tag_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;

        if (rd_en)
        begin
            set_next = split_set;
            tag_next = split_tag;
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_SET)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (!s_axis_tuser)
                    begin
                        res_next.hit      = 1'b0;
                        res_next.delay    = miss_delay_reg;
                        res_next.filled   = 1'b0;
                        res_next.fill_way = '0;
                        state_next        = S_DONE;
                    end
                    else if (split_done)
                    begin
                        state_next = S_LOOK;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (split_done)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                res_next.hit      = lookup.hit;
                res_next.delay    = lookup.hit ? hit_delay_reg : miss_delay_reg;
                res_next.filled   = !lookup.hit;
                res_next.fill_way = lookup.way;
                if (!lookup.hit && lookup.full)
                begin
                    lfsr_next = lfsr_stepped;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            lfsr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            lfsr_reg      <= lfsr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_delay_reg  <= sat_pkg::HIT_DELAY_RESET;
            miss_delay_reg <= sat_pkg::MISS_DELAY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sat_pkg::CFG_HIT_DELAY:  hit_delay_reg  <= cfg_data;
                sat_pkg::CFG_MISS_DELAY: miss_delay_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        set_reg      <= set_next;
        tag_reg      <= tag_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    // The replacement LFSR only moves when a full set is looked up.
    assert property (@(posedge clk) disable iff (!rst_n)
        (lfsr_reg != $past(lfsr_reg)) |-> $past(state_reg == S_LOOK))
        else $error("LFSR stepped outside a lookup");

    // A result never reports both a hit and an allocation.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.hit && out_data_reg.filled))
        else $error("Result reports both hit and fill");

    // The filled way always lies within the configured way count.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (4'(out_data_reg.fill_way) < 4'(NUM_WAYS)))
        else $error("Fill way beyond the way count");

    // A lookup is always followed by the result hand-off.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOK) |=> (state_reg == S_DONE))
        else $error("Lookup not followed by result stage");

endmodule

`default_nettype wire
